>>> hw/rtl/sparse_row_matrix_vector_multiply_macros.svh
// Assertion macros shared by the sparse row matrix-vector multiply RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPARSE_ROW_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define SPARSE_ROW_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SRMVM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srmvm same-cycle check failed");

// Next-cycle implication, disabled in reset
`define SRMVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srmvm next-cycle check failed");

`endif

>>> hw/rtl/srmvm_pkg.sv
// Shared types and constants for the sparse row matrix-vector multiply.
// No dependencies.
package srmvm_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ROW_W  = 10;
  localparam int ACC_W  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_NONZERO = 2'd1;
  localparam logic [1:0] CMD_EMPTY   = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic signed [DATA_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SUM_MIN = 32'sh8000_0000;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     row_end;
    logic                     hit;
  } srmvm_item_t;

endpackage

>>> hw/rtl/sparse_row_matrix_vector_multiply.sv
// The row-ending item passes the front, queue, read, product, accumulate and output registers.
// Throughput: one item per cycle unless the output stalls; the single-port vector RAM
// does one read or write per cycle. A 4-entry queue separates the input front from the
// multiply-accumulate pipeline. Reset clears accumulator, row counter and handshake state;
// the vector store is not cleared. Depends on srmvm_pkg, srmvm_front, srmvm_fifo, srmvm_back.
module sparse_row_matrix_vector_multiply
  import srmvm_pkg::*;
#(
  parameter int VEC_LEN   = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     row_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] row_sum,
  output logic [ROW_W-1:0]         row_number,
  output logic                     saturated
);

  logic        q_full;
  logic        push;
  srmvm_item_t push_item;
  logic        pop;
  logic        q_valid;
  srmvm_item_t q_item;

  srmvm_front #(
    .VEC_LEN (VEC_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .index     (index),
    .value     (value),
    .row_end   (row_end),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  srmvm_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  srmvm_back #(
    .VEC_LEN   (VEC_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_sum    (row_sum),
    .row_number (row_number),
    .saturated  (saturated)
  );

endmodule

>>> hw/rtl/srmvm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module srmvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/srmvm_fifo.sv
// Short queue of classified items between front and back.
// Depends on srmvm_pkg and the shared assertion macros.
`include "sparse_row_matrix_vector_multiply_macros.svh"
module srmvm_fifo
  import srmvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  srmvm_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output srmvm_item_t q_item
);

  srmvm_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `SRMVM_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full)
  `SRMVM_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, q_valid)
  `SRMVM_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= (QPTR_W+1)'(QUEUE_DEPTH))

endmodule

>>> hw/rtl/srmvm_front.sv
// Front end: accepts input items, drops unused commands, flags column range.
// Depends on srmvm_pkg.
module srmvm_front
  import srmvm_pkg::*;
#(
  parameter int VEC_LEN = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     row_end,
  input  logic                     q_full,
  output logic                     push,
  output srmvm_item_t              push_item
);

  logic        fe_valid;
  srmvm_item_t fe_item;
  logic        accept;

  assign push     = fe_valid && !q_full;
  assign in_ready = !fe_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign push_item = fe_item;

  // Hold one classified item; unused commands never enter
  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (accept) begin
      fe_valid <= (command != CMD_NOP);
    end else if (push) begin
      fe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_item.op      <= command;
      fe_item.index   <= index;
      fe_item.value   <= value;
      fe_item.row_end <= row_end;
      fe_item.hit     <= (32'(index) < VEC_LEN);
    end
  end

endmodule

>>> hw/rtl/srmvm_back.sv
// Back end: vector store, multiply, saturating accumulate, row output register.
// Depends on srmvm_pkg, srmvm_ram and the shared assertion macros.
`include "sparse_row_matrix_vector_multiply_macros.svh"
module srmvm_back
  import srmvm_pkg::*;
#(
  parameter int VEC_LEN   = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  srmvm_item_t              q_item,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] row_sum,
  output logic [ROW_W-1:0]         row_number,
  output logic                     saturated
);

  localparam int ADDR_W = $clog2(VEC_LEN);

  logic adv;

  // Read stage (aligned with RAM data)
  logic                     a_valid;
  logic [1:0]               a_op;
  logic signed [DATA_W-1:0] a_value;
  logic                     a_last;
  logic                     a_hit;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] elem;

  // Product stage
  logic                     b_valid;
  logic [1:0]               b_op;
  logic                     b_last;
  logic signed [ACC_W-1:0]  b_prod;

  // Accumulate stage
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sh;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     res_valid;
  logic signed [ACC_W-1:0]  res_sum;
  logic [ROW_W-1:0]         res_row;
  logic [ROW_W-1:0]         row;
  logic [ROW_W-1:0]         row_next;
  logic                     emit;

  logic                     ram_en;
  logic                     ram_we;
  logic                     in_range;

  // Whole back pipeline moves unless the output register is blocked
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  assign ram_en = pop && q_item.hit &&
                  (q_item.op == CMD_LOAD || q_item.op == CMD_NONZERO);
  assign ram_we = (q_item.op == CMD_LOAD);

  srmvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VEC_LEN)
  ) u_vec_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ADDR_W'(q_item.index)),
    .wdata (q_item.value),
    .rdata (rdata)
  );

  // Read stage: loads end at the RAM write
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop && (q_item.op != CMD_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op    <= q_item.op;
      a_value <= q_item.value;
      a_last  <= q_item.row_end;
      a_hit   <= q_item.hit;
    end
  end

  // Product stage: out-of-store columns contribute zero
  assign elem = a_hit ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op   <= a_op;
      b_last <= a_last;
      b_prod <= ACC_W'(a_value) * ACC_W'(elem);
    end
  end

  // Accumulate stage: floor shift, then add saturating at 64-bit limits
  assign sh  = b_prod >>> FRAC_BITS;
  assign sum = acc + sh;

  always_comb begin
    if (!acc[ACC_W-1] && !sh[ACC_W-1] && sum[ACC_W-1]) begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (acc[ACC_W-1] && sh[ACC_W-1] && !sum[ACC_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = sum;
    end
  end

  assign emit     = b_valid && (b_op == CMD_EMPTY || b_last);
  assign row_next = (32'(row) == VEC_LEN - 1) ? '0 : row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      row       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= emit;
      if (b_valid) begin
        if (emit) begin
          acc <= '0;
          row <= row_next;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_sum <= (b_op == CMD_EMPTY) ? '0 : acc_next;
      res_row <= row;
    end
  end

  // Output register: clip to 32 bits
  assign in_range = (&res_sum[ACC_W-1:DATA_W-1]) || !(|res_sum[ACC_W-1:DATA_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_number <= res_row;
      saturated  <= !in_range;
      if (in_range) begin
        row_sum <= res_sum[DATA_W-1:0];
      end else begin
        row_sum <= res_sum[ACC_W-1] ? SUM_MIN : SUM_MAX;
      end
    end
  end

  `SRMVM_ASSERT_IMPL(a_stall_no_pop, clk, rst, out_valid && !out_ready, !pop)
  `SRMVM_ASSERT_NEXT(a_emit_clears, clk, rst, adv && emit, acc == '0)
  `SRMVM_ASSERT_NEXT(a_emit_to_res, clk, rst, adv && emit, res_valid)

endmodule

>>> dv/sparse_row_matrix_vector_multiply_tb.sv
// Testbench for the sparse row matrix-vector multiply: directed rows, random CSR traffic
// under sender gaps and receiver stalls, and row counter wrap, checked by a local predictor.
// Depends on srmvm_pkg and sparse_row_matrix_vector_multiply.
module sparse_row_matrix_vector_multiply_tb
  import srmvm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VEC_LEN        = 1024;
  localparam int FRAC_BITS      = 16;
  localparam int RESET_CYCLES   = 9;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_ITEMS    = 300;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]  ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    logic [ROW_W-1:0]         row;
    logic                     sat;
  } row_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               command = CMD_NOP;
  logic [IDX_W-1:0]         index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     row_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] row_sum;
  logic [ROW_W-1:0]         row_number;
  logic                     saturated;

  // Predictor state
  logic signed [DATA_W-1:0] vec_shadow [VEC_LEN];
  logic signed [ACC_W-1:0]  acc_shadow = '0;
  logic [ROW_W-1:0]         row_shadow = '0;
  row_result_t              pending_rows [$];

  // Stimulus bookkeeping
  bit                       col_loaded [VEC_LEN];
  logic [IDX_W-1:0]         loaded_cols [$];
  int                       items_sent = 0;
  int                       rows_sent = 0;
  int                       send_idle_pct = 0;
  int                       stall_pct = 0;
  int                       fail_count = 0;
  int                       quiet_cycles = 0;

  sparse_row_matrix_vector_multiply #(
    .VEC_LEN  (VEC_LEN),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .index     (index),
    .value     (value),
    .row_end   (row_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_sum   (row_sum),
    .row_number(row_number),
    .saturated (saturated)
  );

  always #1 clk = ~clk;

  // Advance the row model by one accepted item; returns 1 when a row result is due
  function automatic logic step_row_model(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic last, output row_result_t res);
    logic signed [ACC_W-1:0] lhs;
    logic signed [ACC_W-1:0] rhs;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] finished;
    logic                    emit;
    emit = 1'b0;
    finished = '0;
    res = '0;
    case (cmd)
      CMD_LOAD: begin
        vec_shadow[idx] = val;
      end
      CMD_NONZERO: begin
        lhs = ACC_W'(val);
        rhs = ACC_W'(vec_shadow[idx]);
        // Exact Q32.32 product, floored back to Q16.16
        product = (lhs * rhs) >>> FRAC_BITS;
        total = acc_shadow + product;
        // Clip the accumulator at the 64-bit limits
        if (acc_shadow[ACC_W-1] == product[ACC_W-1] && total[ACC_W-1] != acc_shadow[ACC_W-1])
          total = acc_shadow[ACC_W-1] ? ACC_MIN : ACC_MAX;
        acc_shadow = total;
        if (last) begin
          finished = acc_shadow;
          acc_shadow = '0;
          emit = 1'b1;
        end
      end
      CMD_EMPTY: begin
        // Drop any partial sum and report a zero row
        acc_shadow = '0;
        emit = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      if (finished > 64'sd2147483647) begin
        res.sum = SUM_MAX;
        res.sat = 1'b1;
      end else if (finished < -64'sd2147483648) begin
        res.sum = SUM_MIN;
        res.sat = 1'b1;
      end else begin
        res.sum = finished[DATA_W-1:0];
        res.sat = 1'b0;
      end
      res.row = row_shadow;
      row_shadow = row_shadow + 1'b1;
    end
    return emit;
  endfunction

  // Predict on each input transfer, check each output transfer against the oldest row
  always @(posedge clk) begin
    row_result_t predicted;
    row_result_t oldest;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (step_row_model(command, index, value, row_end, predicted))
          pending_rows.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected row result: sum %0d row %0d sat %0b",
                     row_sum, row_number, saturated);
        end else begin
          oldest = pending_rows.pop_front();
          if (row_sum !== oldest.sum || row_number !== oldest.row || saturated !== oldest.sat)
          begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("row mismatch: exp sum %0d row %0d sat %0b, got sum %0d row %0d sat %0b",
                       oldest.sum, oldest.row, oldest.sat, row_sum, row_number, saturated);
          end
        end
      end
    end
  end

  // Stall the result channel at the phase's rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** sparse_row_matrix_vector_multiply: FAILED **");
        $finish;
      end
    end
  end

  // Present one item, holding it until the transfer; called just after a rising edge
  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    index    <= idx;
    value    <= val;
    row_end  <= last;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD && !col_loaded[idx]) begin
      col_loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
    if (cmd != CMD_NOP)
      items_sent++;
    if (cmd == CMD_EMPTY || (cmd == CMD_NONZERO && last))
      rows_sent++;
  endtask

  // Mix of tiny, scaled and extreme Q16.16 values
  function automatic logic signed [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] raw;
    raw = $urandom();
    case ($urandom_range(9))
      0: return SUM_MAX;
      1: return SUM_MIN;
      2: return '0;
      3: return Q_ONE;
      4: return -Q_ONE;
      default: return raw >>> $urandom_range(DATA_W-1);
    endcase
  endfunction

  // Only columns already written are ever read
  function automatic logic [IDX_W-1:0] pick_col();
    return loaded_cols[$urandom_range(loaded_cols.size()-1)];
  endfunction

  // One nonzero, sometimes preceded by a write to the same column
  task automatic send_nonzero(input logic last);
    logic [IDX_W-1:0] col;
    col = pick_col();
    if ($urandom_range(9) == 0)
      send_item(CMD_LOAD, col, rand_value(), 1'($urandom_range(1)));
    send_item(CMD_NONZERO, col, rand_value(), last);
  endtask

  // Random CSR traffic: mostly whole rows, plus loads, empty rows, cut rows and no-ops
  task automatic run_random_rows(input int count);
    int target;
    int kind;
    int len;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 15 || loaded_cols.size() == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(CMD_LOAD, IDX_W'($urandom_range(VEC_LEN-1)), rand_value(),
                    1'($urandom_range(1)));
      end else if (kind < 80) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0)
            send_item(CMD_NOP, IDX_W'($urandom_range(VEC_LEN-1)), $urandom(),
                      1'($urandom_range(1)));
          send_nonzero(i == len - 1);
        end
      end else if (kind < 88) begin
        send_item(CMD_EMPTY, IDX_W'($urandom_range(VEC_LEN-1)), $urandom(),
                  1'($urandom_range(1)));
      end else if (kind < 95) begin
        // Cut a row short with an empty-row command
        repeat ($urandom_range(1, 3))
          send_nonzero(1'b0);
        send_item(CMD_EMPTY, IDX_W'($urandom_range(VEC_LEN-1)), $urandom(),
                  1'($urandom_range(1)));
      end else begin
        send_item(CMD_NOP, IDX_W'($urandom_range(VEC_LEN-1)), $urandom(),
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_directed_rows();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(CMD_LOAD, 10'd0,    Q_ONE,   1'b0);
    send_item(CMD_LOAD, 10'd1023, SUM_MAX, 1'b1);
    send_item(CMD_LOAD, 10'd512,  SUM_MIN, 1'b0);
    send_item(CMD_LOAD, 10'd1,    -32'sd1, 1'b0);
    send_item(CMD_LOAD, 10'h155,  32'sd0,  1'b0);
    // Plain single-nonzero row
    send_item(CMD_NONZERO, 10'd0, 32'sh0002_8000, 1'b1);
    // Positive and negative saturation
    send_item(CMD_NONZERO, 10'd1023, SUM_MAX, 1'b0);
    send_item(CMD_NONZERO, 10'd1023, SUM_MAX, 1'b1);
    send_item(CMD_NONZERO, 10'd512,  SUM_MAX, 1'b1);
    send_item(CMD_NONZERO, 10'd512,  SUM_MIN, 1'b1);
    // Floor rounding of a tiny negative product, then a zero element
    send_item(CMD_NONZERO, 10'd1, 32'sd1, 1'b1);
    send_item(CMD_NONZERO, 10'h155, SUM_MIN, 1'b1);
    // Empty row, then an empty row that cuts a partial sum
    send_item(CMD_EMPTY, 10'd0, 32'sd0, 1'b0);
    send_item(CMD_NONZERO, 10'd0, 32'sh0003_0000, 1'b0);
    send_item(CMD_EMPTY, 10'h3FF, SUM_MIN, 1'b1);
    // No-op inside a row and with the row-end bit set
    send_item(CMD_NONZERO, 10'd0, Q_ONE, 1'b0);
    send_item(CMD_NOP, 10'h3FF, SUM_MAX, 1'b1);
    send_item(CMD_NONZERO, 10'd0, Q_ONE, 1'b1);
    send_item(CMD_NONZERO, 10'd0, -Q_ONE, 1'b1);
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    run_random_rows(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 59;
    stall_pct = 0;
    run_random_rows(PHASE_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct = 59;
    run_random_rows(PHASE_ITEMS);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 12;
    stall_pct = 12;
    run_random_rows(PHASE_ITEMS);
  endtask

  // Push the row number past its last value with short rows
  task automatic test_row_counter_wrap();
    send_idle_pct = 12;
    stall_pct = 12;
    while (rows_sent < VEC_LEN + 8) begin
      if ($urandom_range(1))
        send_item(CMD_EMPTY, IDX_W'($urandom_range(VEC_LEN-1)), $urandom(),
                  1'($urandom_range(1)));
      else
        send_nonzero(1'b1);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_rows();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_row_counter_wrap();
    in_valid <= 1'b0;
    // Drain outstanding rows, then watch for strays
    while (pending_rows.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** sparse_row_matrix_vector_multiply: PASSED **");
    else
      $display("** sparse_row_matrix_vector_multiply: FAILED **");
    $finish;
  end

endmodule
